/* rtl/core/mmqm_pkg.sv */
// Shared types for the multi-mailbox queue manager: opcodes, reply codes,
// the sequencer state and the request/response payload structs.
// No dependencies.
`default_nettype none

package mmqm_pkg;

   typedef enum logic [1:0] {
      FN_OPEN = 2'd0,
      FN_SEND = 2'd1,
      FN_RECV = 2'd2,
      FN_DROP = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      KIND_MAILBOX = 2'd0,
      KIND_STATUS  = 2'd1,
      KIND_RECV    = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_INVALID = 3'd1,
      ST_BUSY    = 3'd2,
      ST_NORES   = 3'd3,
      ST_EMPTY   = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE = 2'd0,
      S_EXEC = 2'd1,
      S_POP  = 2'd2
   } state_type;

   typedef struct packed {
      func_type    func;
      logic [7:0]  mailbox_handle;
      logic [8:0]  message_limit;
      logic [63:0] payload_word;
      logic [3:0]  payload_bytes;
   } req_type;

   typedef struct packed {
      kind_type    reply_kind;
      status_type  status;
      logic [7:0]  new_handle;
      logic [63:0] message_word;
      logic [3:0]  message_bytes;
   } rsp_type;

endpackage

`default_nettype wire

/* rtl/core/multi_mailbox_queue_manager_unit.sv */
// Multi-mailbox queue manager: mailbox table, shared message pool, free list.
// Depends on mmqm_pkg (request/response structs, opcodes, reply codes).
`default_nettype none

//  channel   | direction | handshake             | payload
//  ----------+-----------+-----------------------+-------------------------
//  req_      | in        | req_valid / req_stall | mmqm_pkg::req_type
//  rsp_      | out       | rsp_valid / rsp_stall | mmqm_pkg::rsp_type
//
// One request at a time. Open, send and drop read the box table, then decide
// and write back; a recv that finds a message reads the box table, then the
// pool at the head entry, then writes back, and a failing recv runs like
// open, send and drop. The box table and the pool memories have registered
// reads, which sets these steps.
// Reset is synchronous and needs no clearing pass: pool entries are handed
// out from a fill count until the free list has something on it.
// A result waits in the output register; a stalled result holds the next
// request in its execute or pop state, with no memory writes until the slot frees.

module multi_mailbox_queue_manager_unit #(
   parameter int NUM_MAILBOXES = 16,
   parameter int POOL_DEPTH    = 256,
   parameter int PAYLOAD_BYTES = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire mmqm_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output mmqm_pkg::rsp_type     rsp_data
);

   localparam int BW   = (NUM_MAILBOXES > 1) ? $clog2(NUM_MAILBOXES) : 1;
   localparam int IW   = $clog2(POOL_DEPTH);
   localparam int CW   = $clog2(POOL_DEPTH + 1);
   localparam int CMPW = (CW > 9) ? CW : 9;
   localparam int DW   = 8 * PAYLOAD_BYTES;

   typedef struct packed {
      logic [8:0]    limit;
      logic [CW-1:0] count;
      logic [IW-1:0] head;
      logic [IW-1:0] tail;
   } box_entry_type;

   typedef struct packed {
      logic [3:0]    len;
      logic [DW-1:0] word;
   } pool_entry_type;

   // storage
   box_entry_type  box_mem  [NUM_MAILBOXES];
   pool_entry_type data_mem [POOL_DEPTH];
   logic [IW-1:0]  link_mem [POOL_DEPTH];

   box_entry_type  box_rd_ff;
   pool_entry_type data_rd_ff;
   logic [IW-1:0]  link_rd_ff;

   // memory controls
   logic           box_we, box_re, data_we, data_re, link_we, link_re;
   logic [BW-1:0]  box_wa;
   box_entry_type  box_wd;
   logic [IW-1:0]  data_wa, data_ra, link_wa, link_ra, link_wd;
   pool_entry_type data_wd;

   // control state
   mmqm_pkg::state_type state_ff, state_in;
   logic [NUM_MAILBOXES-1:0] live_ff, live_in;
   logic [IW-1:0] free_head_ff, free_head_in;   // top of the recycled list
   logic [CW-1:0] list_cnt_ff, list_cnt_in;     // entries on the recycled list
   logic [CW-1:0] fill_ff, fill_in;             // pool entries ever handed out

   // latched request and lookups done at accept
   mmqm_pkg::req_type req_q_ff;
   logic [BW-1:0] hidx_ff, open_idx_ff;
   logic          hok_ff, open_ok_ff;

   // output register
   logic              rsp_valid_ff, rsp_valid_in, rsp_load;
   mmqm_pkg::rsp_type rsp_data_ff, rsp_new;

   logic          req_accept, can_emit;
   logic [BW-1:0] req_hidx, free_idx;
   logic          req_hok, free_any;
   logic          box_full, pool_empty, list_nonempty;
   logic [IW-1:0] alloc_e;
   logic [3:0]    send_len;
   logic [DW-1:0] send_word;

   assign req_stall  = (state_ff != mmqm_pkg::S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign can_emit   = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   // handle check against the live bits; out-of-range handles never match
   always_comb begin
      req_hidx = BW'(req_data.mailbox_handle - 8'd1);
      req_hok  = (req_data.mailbox_handle != 8'd0) &&
                 (req_data.mailbox_handle <= 8'(NUM_MAILBOXES)) &&
                 live_ff[req_hidx];
   end

   // lowest free mailbox
   always_comb begin
      free_idx = '0;
      free_any = 1'b0;
      for (int i = NUM_MAILBOXES - 1; i >= 0; i--) begin
         if (!live_ff[i]) begin
            free_idx = BW'(i);
            free_any = 1'b1;
         end
      end
   end

   // send payload: clamp length, zero bytes past it
   always_comb begin
      send_len = (req_q_ff.payload_bytes > 4'(PAYLOAD_BYTES)) ?
                 4'(PAYLOAD_BYTES) : req_q_ff.payload_bytes;
      for (int i = 0; i < PAYLOAD_BYTES; i++) begin
         send_word[8*i +: 8] = (4'(i) < send_len) ?
                               req_q_ff.payload_word[8*i +: 8] : 8'h00;
      end
   end

   assign box_full      = (box_rd_ff.limit != 9'd0) &&
                          (CMPW'(box_rd_ff.count) >= CMPW'(box_rd_ff.limit));
   assign list_nonempty = (list_cnt_ff != '0);
   assign pool_empty    = !list_nonempty && (fill_ff == CW'(POOL_DEPTH));
   assign alloc_e       = list_nonempty ? free_head_ff : fill_ff[IW-1:0];

   // sequencer: next state, memory accesses, reply
   always_comb begin
      state_in     = state_ff;
      live_in      = live_ff;
      free_head_in = free_head_ff;
      list_cnt_in  = list_cnt_ff;
      fill_in      = fill_ff;
      box_re       = 1'b0;
      box_we       = 1'b0;
      box_wa       = hidx_ff;
      box_wd       = box_rd_ff;
      data_we      = 1'b0;
      data_wa      = alloc_e;
      data_wd      = '{len: send_len, word: send_word};
      data_re      = 1'b0;
      data_ra      = box_rd_ff.head;
      link_we      = 1'b0;
      link_wa      = box_rd_ff.tail;
      link_wd      = alloc_e;
      link_re      = 1'b0;
      link_ra      = free_head_ff;
      rsp_load     = 1'b0;
      rsp_new      = '0;

      unique case (state_ff)
         mmqm_pkg::S_IDLE: begin
            if (req_accept) begin
               box_re   = 1'b1;
               link_re  = 1'b1;     // prefetch next link of the free list
               state_in = mmqm_pkg::S_EXEC;
            end
         end

         mmqm_pkg::S_EXEC: begin
            if (can_emit) begin
               rsp_load = 1'b1;
               state_in = mmqm_pkg::S_IDLE;
               rsp_new.status = mmqm_pkg::ST_OK;
               unique case (req_q_ff.func)
                  mmqm_pkg::FN_OPEN: begin
                     rsp_new.reply_kind = mmqm_pkg::KIND_MAILBOX;
                     if (open_ok_ff) begin
                        box_we  = 1'b1;
                        box_wa  = open_idx_ff;
                        box_wd  = '{limit: req_q_ff.message_limit, count: '0,
                                    head: '0, tail: '0};
                        live_in[open_idx_ff] = 1'b1;
                        rsp_new.new_handle = 8'(open_idx_ff) + 8'd1;
                     end else begin
                        rsp_new.status = mmqm_pkg::ST_NORES;
                     end
                  end

                  mmqm_pkg::FN_SEND: begin
                     rsp_new.reply_kind = mmqm_pkg::KIND_STATUS;
                     if (!hok_ff) begin
                        rsp_new.status = mmqm_pkg::ST_INVALID;
                     end else if (box_full) begin
                        rsp_new.status = mmqm_pkg::ST_BUSY;
                     end else if (pool_empty) begin
                        rsp_new.status = mmqm_pkg::ST_NORES;
                     end else begin
                        data_we = 1'b1;
                        if (list_nonempty) begin
                           free_head_in = link_rd_ff;
                           list_cnt_in  = list_cnt_ff - CW'(1);
                        end else begin
                           fill_in = fill_ff + CW'(1);
                        end
                        // chain behind the old tail unless the queue was empty
                        link_we      = (box_rd_ff.count != '0);
                        box_we       = 1'b1;
                        box_wd.count = box_rd_ff.count + CW'(1);
                        box_wd.tail  = alloc_e;
                        if (box_rd_ff.count == '0) begin
                           box_wd.head = alloc_e;
                        end
                     end
                  end

                  mmqm_pkg::FN_RECV: begin
                     rsp_new.reply_kind = mmqm_pkg::KIND_RECV;
                     if (!hok_ff) begin
                        rsp_new.status = mmqm_pkg::ST_INVALID;
                     end else if (box_rd_ff.count == '0) begin
                        rsp_new.status = mmqm_pkg::ST_EMPTY;
                     end else begin
                        // fetch head entry; reply comes from S_POP
                        rsp_load = 1'b0;
                        data_re  = 1'b1;
                        link_re  = 1'b1;
                        link_ra  = box_rd_ff.head;
                        state_in = mmqm_pkg::S_POP;
                     end
                  end

                  mmqm_pkg::FN_DROP: begin
                     rsp_new.reply_kind = mmqm_pkg::KIND_STATUS;
                     if (!hok_ff) begin
                        rsp_new.status = mmqm_pkg::ST_INVALID;
                     end else if (box_rd_ff.count != '0) begin
                        rsp_new.status = mmqm_pkg::ST_BUSY;
                     end else begin
                        live_in[hidx_ff] = 1'b0;
                     end
                  end

                  default: begin
                     rsp_new.reply_kind = mmqm_pkg::KIND_STATUS;
                  end
               endcase
            end
         end

         mmqm_pkg::S_POP: begin
            if (can_emit) begin
               // advance head, push the freed entry on the recycled list
               box_we       = 1'b1;
               box_wd.count = box_rd_ff.count - CW'(1);
               box_wd.head  = link_rd_ff;
               link_we      = 1'b1;
               link_wa      = box_rd_ff.head;
               link_wd      = free_head_ff;
               free_head_in = box_rd_ff.head;
               list_cnt_in  = list_cnt_ff + CW'(1);
               rsp_load     = 1'b1;
               rsp_new.reply_kind    = mmqm_pkg::KIND_RECV;
               rsp_new.status        = mmqm_pkg::ST_OK;
               rsp_new.message_word  = 64'(data_rd_ff.word);
               rsp_new.message_bytes = data_rd_ff.len;
               state_in = mmqm_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = mmqm_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // memories: one write and one registered read each
   always_ff @(posedge clock) begin
      if (box_we) begin
         box_mem[box_wa] <= box_wd;
      end
      if (box_re) begin
         box_rd_ff <= box_mem[req_hidx];
      end
   end

   always_ff @(posedge clock) begin
      if (data_we) begin
         data_mem[data_wa] <= data_wd;
      end
      if (data_re) begin
         data_rd_ff <= data_mem[data_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_wa] <= link_wd;
      end
      if (link_re) begin
         link_rd_ff <= link_mem[link_ra];
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (req_accept) begin
         req_q_ff    <= req_data;
         hidx_ff     <= req_hidx;
         hok_ff      <= req_hok;
         open_idx_ff <= free_idx;
         open_ok_ff  <= free_any;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= rsp_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mmqm_pkg::S_IDLE;
         live_ff      <= '0;
         free_head_ff <= '0;
         list_cnt_ff  <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         live_ff      <= live_in;
         free_head_ff <= free_head_in;
         list_cnt_ff  <= list_cnt_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // checks
   a_accept_starts_exec: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff == mmqm_pkg::S_EXEC)
      else $error("accepted request did not enter execute");

   a_list_within_fill: assert property (@(posedge clock) disable iff (reset)
      list_cnt_ff <= fill_ff)
      else $error("free list longer than entries ever handed out");

   a_pop_only_recv: assert property (@(posedge clock) disable iff (reset)
      state_ff == mmqm_pkg::S_POP |-> req_q_ff.func == mmqm_pkg::FN_RECV)
      else $error("pop phase for a non-recv request");

   a_no_reply_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> state_ff != mmqm_pkg::S_IDLE)
      else $error("reply loaded without a request in flight");

endmodule

`default_nettype wire

/* tb/sv/mailbox_reply_checker.sv */
// Reply checker for the multi-mailbox queue manager: watches both channels,
// keeps its own copy of the mailbox table and message pool, and compares.
// Depends on mmqm_pkg (request/response structs, opcodes, reply codes).

module mailbox_reply_checker #(
   parameter int NUM_BOXES  = 16,
   parameter int POOL_SLOTS = 256,
   parameter int WORD_BYTES = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_stall,
   input  wire mmqm_pkg::req_type req_data,
   input  wire logic              rsp_valid,
   input  wire logic              rsp_stall,
   input  wire mmqm_pkg::rsp_type rsp_data,
   output int unsigned            mismatch_count,
   output int unsigned            replies_checked,
   output int unsigned            replies_owed
);

   logic        box_live  [NUM_BOXES];
   logic [8:0]  box_limit [NUM_BOXES];
   logic [8:0]  box_count [NUM_BOXES];
   logic [7:0]  box_head  [NUM_BOXES];
   logic [7:0]  box_tail  [NUM_BOXES];
   logic [63:0] msg_word  [POOL_SLOTS];
   logic [3:0]  msg_len   [POOL_SLOTS];
   logic [7:0]  msg_next  [POOL_SLOTS];
   logic [7:0]  free_slots[POOL_SLOTS];
   logic [8:0]  free_total;

   mmqm_pkg::rsp_type pending_replies[$];
   mmqm_pkg::rsp_type want;

   function automatic void clear_tables();
      for (int i = 0; i < NUM_BOXES; i++) begin
         box_live[i]  = 1'b0;
         box_limit[i] = '0;
         box_count[i] = '0;
         box_head[i]  = '0;
         box_tail[i]  = '0;
      end
      for (int i = 0; i < POOL_SLOTS; i++) begin
         msg_word[i]   = '0;
         msg_len[i]    = '0;
         msg_next[i]   = '0;
         free_slots[i] = 8'(POOL_SLOTS - 1 - i);
      end
      free_total = 9'(POOL_SLOTS);
   endfunction

   // Reply that one mailbox command yields; updates the tables as it goes.
   function automatic mmqm_pkg::rsp_type mailbox_reply(input mmqm_pkg::req_type r);
      mmqm_pkg::rsp_type y;
      int                slot;
      int                pick;
      logic [3:0]        len;
      logic [63:0]       word;
      logic [7:0]        ent;
      y    = '0;
      slot = -1;
      pick = -1;
      if (r.mailbox_handle != 0 && r.mailbox_handle <= NUM_BOXES &&
          box_live[r.mailbox_handle - 1])
         slot = r.mailbox_handle - 1;
      case (r.func)
         mmqm_pkg::FN_OPEN: begin
            y.reply_kind = mmqm_pkg::KIND_MAILBOX;
            // lowest free mailbox wins
            for (int i = NUM_BOXES - 1; i >= 0; i--)
               if (!box_live[i]) pick = i;
            if (pick < 0) begin
               y.status = mmqm_pkg::ST_NORES;
            end else begin
               box_live[pick]  = 1'b1;
               box_limit[pick] = r.message_limit;
               box_count[pick] = '0;
               y.status        = mmqm_pkg::ST_OK;
               y.new_handle    = 8'(pick + 1);
            end
         end
         mmqm_pkg::FN_SEND: begin
            y.reply_kind = mmqm_pkg::KIND_STATUS;
            if (slot < 0) begin
               y.status = mmqm_pkg::ST_INVALID;
            end else if (box_limit[slot] != 0 && box_count[slot] >= box_limit[slot]) begin
               y.status = mmqm_pkg::ST_BUSY;
            end else if (free_total == 0) begin
               y.status = mmqm_pkg::ST_NORES;
            end else begin
               len  = (r.payload_bytes > WORD_BYTES) ? 4'(WORD_BYTES) : r.payload_bytes;
               word = r.payload_word;
               if (len < 8)
                  word &= (64'd1 << (8 * len)) - 64'd1;
               free_total    = free_total - 9'd1;
               ent           = free_slots[free_total];
               msg_word[ent] = word;
               msg_len[ent]  = len;
               msg_next[ent] = '0;
               if (box_count[slot] == 0)
                  box_head[slot] = ent;
               else
                  msg_next[box_tail[slot]] = ent;
               box_tail[slot]  = ent;
               box_count[slot] = box_count[slot] + 9'd1;
               y.status        = mmqm_pkg::ST_OK;
            end
         end
         mmqm_pkg::FN_RECV: begin
            y.reply_kind = mmqm_pkg::KIND_RECV;
            if (slot < 0) begin
               y.status = mmqm_pkg::ST_INVALID;
            end else if (box_count[slot] == 0) begin
               y.status = mmqm_pkg::ST_EMPTY;
            end else begin
               ent             = box_head[slot];
               box_head[slot]  = msg_next[ent];
               box_count[slot] = box_count[slot] - 9'd1;
               if (free_total < POOL_SLOTS) begin
                  free_slots[free_total] = ent;
                  free_total             = free_total + 9'd1;
               end
               y.status        = mmqm_pkg::ST_OK;
               y.message_word  = msg_word[ent];
               y.message_bytes = msg_len[ent];
            end
         end
         default: begin
            y.reply_kind = mmqm_pkg::KIND_STATUS;
            if (slot < 0) begin
               y.status = mmqm_pkg::ST_INVALID;
            end else if (box_count[slot] != 0) begin
               y.status = mmqm_pkg::ST_BUSY;
            end else begin
               box_live[slot]  = 1'b0;
               box_limit[slot] = '0;
               box_count[slot] = '0;
               y.status        = mmqm_pkg::ST_OK;
            end
         end
      endcase
      return y;
   endfunction

   task automatic flag_field(input string field, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
      $display("%0t: reply %0d mismatch in %s: expected %0h, actual %0h",
               $time, replies_checked, field, exp_v, act_v);
   endtask

   // Replies are compared before the request of the same edge is predicted;
   // no reply can belong to a request accepted at that very edge.
   always @(posedge clock) begin
      if (reset) begin
         clear_tables();
         pending_replies.delete();
         mismatch_count  = 0;
         replies_checked = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_replies.size() == 0) begin
               $display("%0t: unexpected reply, expected none, actual %0h",
                        $time, rsp_data);
               mismatch_count++;
            end else begin
               want = pending_replies.pop_front();
               if (want != rsp_data) begin
                  mismatch_count++;
                  if (want.reply_kind != rsp_data.reply_kind)
                     flag_field("reply_kind", 64'(want.reply_kind),
                                64'(rsp_data.reply_kind));
                  if (want.status != rsp_data.status)
                     flag_field("status", 64'(want.status), 64'(rsp_data.status));
                  if (want.new_handle != rsp_data.new_handle)
                     flag_field("new_handle", 64'(want.new_handle),
                                64'(rsp_data.new_handle));
                  if (want.message_word != rsp_data.message_word)
                     flag_field("message_word", want.message_word, rsp_data.message_word);
                  if (want.message_bytes != rsp_data.message_bytes)
                     flag_field("message_bytes", 64'(want.message_bytes),
                                64'(rsp_data.message_bytes));
               end
               replies_checked++;
            end
         end
         if (req_valid && !req_stall)
            pending_replies.push_back(mailbox_reply(req_data));
      end
      replies_owed <= pending_replies.size();
   end

endmodule

/* tb/sv/multi_mailbox_queue_manager_unit_tb.sv */
// Testbench top for the multi-mailbox queue manager: clock, reset, request
// stimulus and reply back-pressure; checking is done by mailbox_reply_checker.
// Depends on mmqm_pkg, mailbox_reply_checker and the unit under test.

module multi_mailbox_queue_manager_unit_tb;

   localparam int RESET_CYCLES = 6;
   localparam int RANDOM_ITEMS = 1400;
   localparam int CALM_ITEMS   = 200;   // tail of the run with no idling
   localparam int LONG_HOLD    = 200;   // reply hold-off during the pool fill
   localparam int SETTLE       = 8;
   localparam int CYCLE_LIMIT  = 300000;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   mmqm_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   mmqm_pkg::rsp_type rsp_data;

   int unsigned mismatch_count;
   int unsigned replies_checked;
   int unsigned replies_owed;

   // Idling switches set by the sender; hold-offs asked and served are
   // counted on separate sides.
   bit          tx_bursts    = 1'b1;
   bit          rx_bursts    = 1'b1;
   int unsigned hold_asks    = 0;
   int unsigned hold_done    = 0;
   int unsigned cycle_count  = 0;
   int unsigned func_seen[4] = '{0, 0, 0, 0};

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   multi_mailbox_queue_manager_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   mailbox_reply_checker checker_i (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data        (rsp_data),
      .mismatch_count  (mismatch_count),
      .replies_checked (replies_checked),
      .replies_owed    (replies_owed)
   );

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Reply side. A requested long hold-off is counted here; otherwise, while bursts
   // are on, stall comes in short random bursts separated by open stretches.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_done != hold_asks) begin
            hold_done = hold_asks;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (rx_bursts && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
            rsp_stall <= 1'b0;
            repeat ($urandom_range(0, 20)) @(posedge clock);
         end
      end
   end

   function automatic mmqm_pkg::req_type mk_request(input mmqm_pkg::func_type f,
                                                    input logic [7:0] h,
                                                    input logic [8:0] lim,
                                                    input logic [63:0] w,
                                                    input logic [3:0] nb);
      mmqm_pkg::req_type r;
      r.func           = f;
      r.mailbox_handle = h;
      r.message_limit  = lim;
      r.payload_word   = w;
      r.payload_bytes  = nb;
      return r;
   endfunction

   // Mostly commands on real mailboxes; a fifth or so carry junk handles.
   function automatic mmqm_pkg::req_type random_request();
      mmqm_pkg::req_type r;
      int unsigned       pick;
      r.payload_word = {$urandom, $urandom};
      pick = $urandom_range(0, 99);
      if (pick < 12)      r.func = mmqm_pkg::FN_OPEN;
      else if (pick < 50) r.func = mmqm_pkg::FN_SEND;
      else if (pick < 88) r.func = mmqm_pkg::FN_RECV;
      else                r.func = mmqm_pkg::FN_DROP;
      case ($urandom_range(0, 9))
         8:       r.mailbox_handle = 8'd0;
         9:       r.mailbox_handle = 8'($urandom_range(0, 255));
         default: r.mailbox_handle = 8'($urandom_range(1, 16));
      endcase
      case ($urandom_range(0, 3))
         0:       r.message_limit = 9'd0;
         1:       r.message_limit = 9'd256;
         2:       r.message_limit = 9'($urandom_range(0, 256));
         default: r.message_limit = 9'($urandom_range(1, 4));
      endcase
      // lengths past a full word get saturated by the block
      if ($urandom_range(0, 3) == 0)
         r.payload_bytes = 4'($urandom_range(0, 15));
      else
         r.payload_bytes = 4'($urandom_range(0, 8));
      return r;
   endfunction

   // Offer one request and hold it until accepted. Valid is left high so a
   // following request goes out back to back.
   task automatic issue(input mmqm_pkg::req_type r);
      req_data  <= r;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      func_seen[r.func]++;
   endtask

   task automatic sender_gap();
      if (tx_bursts && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   // Stop sending until every owed reply is back. The owed count is polled only
   // once the checker has counted the request accepted last.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (replies_owed != 0) @(posedge clock);
   endtask

   task automatic issue_gap(input mmqm_pkg::req_type r);
      issue(r);
      sender_gap();
   endtask

   localparam logic [63:0] ONES = 64'hFFFF_FFFF_FFFF_FFFF;

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // --- directed: bad handles from reset, limits, masking, busy drop ---
      issue_gap(mk_request(mmqm_pkg::FN_RECV, 8'd1,   9'd0,   ONES, 4'd8));   // not live
      issue_gap(mk_request(mmqm_pkg::FN_SEND, 8'd0,   9'd0,   ONES, 4'd8));   // handle zero
      issue_gap(mk_request(mmqm_pkg::FN_DROP, 8'd255, 9'd511, ONES, 4'd15));  // out of range
      issue_gap(mk_request(mmqm_pkg::FN_OPEN, 8'd0,   9'd0,   '0,   4'd0));   // unlimited -> 1
      issue_gap(mk_request(mmqm_pkg::FN_OPEN, 8'd255, 9'd256, '0,   4'd0));   // limit 256 -> 2
      issue_gap(mk_request(mmqm_pkg::FN_OPEN, 8'd0,   9'd1,   '0,   4'd0));   // limit 1 -> 3
      issue_gap(mk_request(mmqm_pkg::FN_SEND, 8'd3,   9'd0,   ONES, 4'd0));   // zero-length
      issue_gap(mk_request(mmqm_pkg::FN_SEND, 8'd3,   9'd0,   ONES, 4'd4));   // box full
      issue_gap(mk_request(mmqm_pkg::FN_RECV, 8'd3,   9'd0,   '0,   4'd0));
      issue_gap(mk_request(mmqm_pkg::FN_RECV, 8'd3,   9'd0,   '0,   4'd0));   // now empty
      issue_gap(mk_request(mmqm_pkg::FN_SEND, 8'd1,   9'd0,   ONES, 4'd15));  // long payload
      issue_gap(mk_request(mmqm_pkg::FN_SEND, 8'd1,   9'd0, {$urandom, $urandom}, 4'd8));
      issue_gap(mk_request(mmqm_pkg::FN_SEND, 8'd1,   9'd0,   ONES, 4'd1));   // low byte only
      issue_gap(mk_request(mmqm_pkg::FN_DROP, 8'd1,   9'd0,   '0,   4'd0));   // not empty
      repeat (3) issue_gap(mk_request(mmqm_pkg::FN_RECV, 8'd1, 9'd0, '0, 4'd0));
      issue_gap(mk_request(mmqm_pkg::FN_DROP, 8'd1,   9'd0,   '0,   4'd0));
      issue_gap(mk_request(mmqm_pkg::FN_SEND, 8'd1,   9'd0,   ONES, 4'd8));   // dropped box
      issue_gap(mk_request(mmqm_pkg::FN_RECV, 8'd17,  9'd0,   '0,   4'd0));   // past table
      issue_gap(mk_request(mmqm_pkg::FN_DROP, 8'd3,   9'd0,   '0,   4'd0));
      issue_gap(mk_request(mmqm_pkg::FN_OPEN, 8'd0,   9'd5,   '0,   4'd0));   // reuses slot 1
      issue_gap(mk_request(mmqm_pkg::FN_DROP, 8'd1,   9'd0,   '0,   4'd0));
      drain();

      // --- pool fill through mailbox 2 under a long reply hold-off ---
      // The block backs up and stalls requests while the sender keeps going.
      hold_asks = hold_asks + 1;
      repeat (256)
         issue_gap(mk_request(mmqm_pkg::FN_SEND, 8'd2, 9'($urandom),
                              {$urandom, $urandom}, 4'($urandom_range(0, 15))));
      issue_gap(mk_request(mmqm_pkg::FN_SEND, 8'd2, 9'd0, ONES, 4'd8));   // at limit 256
      issue_gap(mk_request(mmqm_pkg::FN_OPEN, 8'd0, 9'd0, '0,   4'd0));   // -> 1
      issue_gap(mk_request(mmqm_pkg::FN_SEND, 8'd1, 9'd0, ONES, 4'd8));   // pool exhausted
      issue_gap(mk_request(mmqm_pkg::FN_DROP, 8'd2, 9'd0, '0,   4'd0));   // still full
      repeat (256) issue_gap(mk_request(mmqm_pkg::FN_RECV, 8'd2, 9'd0, '0, 4'd0));
      issue_gap(mk_request(mmqm_pkg::FN_DROP, 8'd2, 9'd0, '0, 4'd0));
      issue_gap(mk_request(mmqm_pkg::FN_DROP, 8'd1, 9'd0, '0, 4'd0));
      drain();

      // --- random command mix; the tail runs without idling on either side ---
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS - CALM_ITEMS) begin
            tx_bursts = 1'b0;
            rx_bursts = 1'b0;
         end
         issue_gap(random_request());
      end
      drain();
      repeat (SETTLE) @(posedge clock);

      $display("Covered %0d requests: %0d open, %0d send, %0d recv, %0d drop,",
               func_seen[mmqm_pkg::FN_OPEN] + func_seen[mmqm_pkg::FN_SEND] +
               func_seen[mmqm_pkg::FN_RECV] + func_seen[mmqm_pkg::FN_DROP],
               func_seen[mmqm_pkg::FN_OPEN], func_seen[mmqm_pkg::FN_SEND],
               func_seen[mmqm_pkg::FN_RECV], func_seen[mmqm_pkg::FN_DROP]);
      $display("incl. pool exhaustion and a %0d-cycle reply hold; %0d replies, %0d bad.",
               LONG_HOLD, replies_checked, mismatch_count);
      if (mismatch_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

/* sim.f */
rtl/core/mmqm_pkg.sv
rtl/core/multi_mailbox_queue_manager_unit.sv
tb/sv/mailbox_reply_checker.sv
tb/sv/multi_mailbox_queue_manager_unit_tb.sv
